>>> src/cpdt_pkg.sv
// shared types, codes and a range helper for the cidr prefix table
// no dependencies
`default_nettype none
package cpdt_pkg;
    localparam int TABLE_DEPTH_DEF = 32;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_COVERED  = 3'd1,
        ST_FULL     = 3'd2,
        ST_DUMP     = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DUMP   = 1'b1;

    // per-cell control broadcast from the controller
    typedef struct packed {
        logic        probe;    // compare stored range against probe range
        logic        compact;  // shift-left compaction step
        logic        dump;     // rotate one word toward the head
        logic [31:0] lo;
        logic [31:0] hi;
    } cell_ctl_t;

    function automatic logic [31:0] range_mask(input logic [5:0] len);
        logic [31:0] m;
        if (len == 6'd0) m = 32'h0;
        else if (len >= 6'd32) m = 32'hffff_ffff;
        else m = 32'hffff_ffff << (6'd32 - len);
        return m;
    endfunction
endpackage
`default_nettype wire

>>> src/cpdt_cell.sv
// one table slot: holds an entry, compares it to the probe range and shifts
// depends on cpdt_pkg
`default_nettype none
module cpdt_cell (
    input  wire logic               aclk,
    input  wire cpdt_pkg::cell_ctl_t ctl,
    input  wire logic               wr_en,      // load new entry
    input  wire logic [31:0]        wr_addr,
    input  wire logic [5:0]         wr_len,
    input  wire logic               take_next,  // load from right neighbor
    input  wire logic [31:0]        nxt_addr,
    input  wire logic [5:0]         nxt_len,
    output logic [31:0]             addr,
    output logic [5:0]              len,
    output logic                    covers,     // stored range holds the probe
    output logic                    enclosed    // stored range lies in the probe
);
    import cpdt_pkg::*;
    logic [31:0] addr_reg, addr_next;
    logic [5:0]  len_reg, len_next;
    logic [31:0] m, slo, shi;

    always_comb begin
        m   = range_mask(len_reg);
        slo = addr_reg & m;
        shi = slo | ~m;
        covers = (ctl.lo >= slo) && (ctl.hi <= shi);
        enclosed = (ctl.lo <= slo) && (ctl.hi >= shi);
        addr_next = addr_reg;
        len_next  = len_reg;
        if (wr_en) begin
            addr_next = wr_addr;
            len_next  = wr_len;
        end else if (take_next) begin
            addr_next = nxt_addr;
            len_next  = nxt_len;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        len_reg  <= len_next;
    end

    assign addr = addr_reg;
    assign len  = len_reg;
endmodule
`default_nettype wire

>>> src/cidr_prefix_dedup_table.sv
// top level: chain of prefix cells plus the insert/dump sequencer
// depends on cpdt_pkg, cpdt_cell
//
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    s_func s_ip_addr s_prefix_len
// m_       out  m_valid/m_ready    m_status m_removed_count m_entry_count
//                                  m_out_addr m_out_len m_last
//
// insert: accept, a PROBE state comparing all cells at once, COMPACT steps
// that each drop the lowest marked removed entry until none is left, a RESP
// append step (also taken by a full table), then the result word; a covered
// insert presents its word straight after the PROBE state.
// dump: first word the cycle after accept, the chain rotates one cell per
// accepted word. reset clears the entry count; cell contents need no reset.
// a stalled m_ready holds the current word and the chain; s_ready is low
// from accept until the last word of the item is taken.
`default_nettype none
module cidr_prefix_dedup_table #(
    parameter int TABLE_DEPTH = cpdt_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_func,
    input  wire logic [31:0] s_ip_addr,
    input  wire logic [5:0]  s_prefix_len,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [5:0]       m_removed_count,
    output logic [5:0]       m_entry_count,
    output logic [31:0]      m_out_addr,
    output logic [5:0]       m_out_len,
    output logic             m_last
);
    import cpdt_pkg::*;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {IDLE, PROBE, COMPACT, DUMP, RESP} state_t;
    state_t state_reg;

    logic [CW-1:0] total_reg, removed_reg, dump_idx_reg;
    logic [31:0] addr_reg;
    logic [5:0]  len_reg;
    logic [TABLE_DEPTH-1:0] mark_reg;

    cell_ctl_t ctl;
    logic [31:0] c_addr [TABLE_DEPTH];
    logic [5:0]  c_len  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] c_cov, c_ins, valid_v, shift_v, wr_v;
    logic [TABLE_DEPTH-1:0] low_mark, below;
    logic [31:0] pm;

    always_comb begin
        pm = range_mask(len_reg);
        ctl.lo = addr_reg & pm;
        ctl.hi = ctl.lo | ~pm;
        ctl.probe = (state_reg == PROBE);
        ctl.compact = (state_reg == COMPACT);
        ctl.dump = (state_reg == DUMP) && m_ready && m_valid;
        for (int i = 0; i < TABLE_DEPTH; i++)
            valid_v[i] = (i < int'(total_reg));
        low_mark = mark_reg & (~mark_reg + TABLE_DEPTH'(1));
        below = low_mark - TABLE_DEPTH'(1);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            shift_v[i] = ctl.dump || (ctl.compact && !below[i]);
            wr_v[i] = (state_reg == RESP) && (m_status == ST_INSERTED)
                      && (i == int'(total_reg)) && !m_valid;
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        localparam int NX = (g + 1) % TABLE_DEPTH;
        cpdt_cell u_cell (
            .aclk(aclk), .ctl(ctl),
            .wr_en(wr_v[g]), .wr_addr(addr_reg), .wr_len(len_reg),
            .take_next(shift_v[g]),
            .nxt_addr(ctl.dump && (NX == 0 || g + 1 >= int'(total_reg))
                      ? c_addr[0] : c_addr[NX]),
            .nxt_len(ctl.dump && (NX == 0 || g + 1 >= int'(total_reg))
                      ? c_len[0] : c_len[NX]),
            .addr(c_addr[g]), .len(c_len[g]),
            .covers(c_cov[g]), .enclosed(c_ins[g])
        );
    end

    assign s_ready = (state_reg == IDLE);
    assign m_out_addr = (state_reg == DUMP && total_reg != '0) ? c_addr[0] : 32'h0;
    assign m_out_len  = (state_reg == DUMP && total_reg != '0) ? c_len[0] : 6'h0;
    assign m_entry_count = 6'(total_reg);
    assign m_removed_count = (state_reg == RESP) ? 6'(removed_reg) : 6'h0;
    assign m_last = (state_reg == RESP) || (total_reg == '0)
                    || (dump_idx_reg + CW'(1) == total_reg);

    logic [2:0] status_reg;
    assign m_status = status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            total_reg <= '0;
            m_valid   <= 1'b0;
        end else begin
            unique case (state_reg)
                IDLE: if (s_valid) begin
                    addr_reg <= s_ip_addr;
                    len_reg  <= (s_prefix_len > 6'd32) ? 6'd32 : s_prefix_len;
                    dump_idx_reg <= '0;
                    removed_reg  <= '0;
                    if (s_func == FUNC_DUMP) begin
                        state_reg  <= DUMP;
                        status_reg <= (total_reg == '0) ? ST_EMPTY : ST_DUMP;
                        m_valid    <= 1'b1;
                    end else begin
                        state_reg <= PROBE;
                    end
                end
                PROBE: begin
                    mark_reg <= c_ins & valid_v;
                    if (|(c_cov & valid_v)) begin
                        removed_reg <= '0;
                        status_reg <= ST_COVERED;
                        state_reg <= RESP;
                        m_valid <= 1'b1;
                    end else begin
                        removed_reg <= CW'($countones(c_ins & valid_v));
                        if ((c_ins & valid_v) == '0) begin
                            status_reg <= (total_reg == CW'(TABLE_DEPTH)) ? ST_FULL
                                                                         : ST_INSERTED;
                            state_reg <= RESP;
                        end else begin
                            status_reg <= ST_INSERTED;
                            state_reg <= COMPACT;
                        end
                    end
                end
                COMPACT: begin
                    // drop lowest marked cell; marks above shift down with it
                    mark_reg <= ((mark_reg & ~low_mark) >> 1) & ~below
                                | (mark_reg & below);
                    total_reg <= total_reg - CW'(1);
                    if ((mark_reg & ~low_mark) == '0) state_reg <= RESP;
                end
                RESP: begin
                    if (!m_valid) begin
                        m_valid <= 1'b1;
                        if (status_reg == ST_INSERTED) total_reg <= total_reg + CW'(1);
                        else removed_reg <= '0;
                    end else if (m_ready) begin
                        m_valid <= 1'b0;
                        state_reg <= IDLE;
                    end
                end
                DUMP: if (m_ready) begin
                    if (m_last) begin
                        m_valid <= 1'b0;
                        state_reg <= IDLE;
                    end else dump_idx_reg <= dump_idx_reg + CW'(1);
                end
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> src/cpdt_checker.sv
// port-level checks for the prefix table, bound to the top level
// depends on cpdt_pkg
`default_nettype none
module cpdt_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [2:0] m_status,
    input wire logic [5:0] m_removed_count,
    input wire logic [31:0] m_out_addr,
    input wire logic       m_last
);
    import cpdt_pkg::*;
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken during output");
    a_dump_zero_removed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == ST_DUMP || m_status == ST_EMPTY))
        |-> m_removed_count == 6'd0) else $error("dump removed nonzero");
    a_insert_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_DUMP) |-> m_last) else $error("last missing");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_out_addr))
        else $error("word dropped");
endmodule
bind cidr_prefix_dedup_table cpdt_checker u_chk (.*);
`default_nettype wire
